>>> rtl/gsv_pkg.sv
package gsv_pkg;

  // Width of the result count fields
  localparam int unsigned TotalWidth = 16;

  // Byte classes
  localparam logic [7:0] AsciiMax   = 8'h7F;
  localparam logic [7:0] CtrlLimit  = 8'h20;
  localparam logic [7:0] LeadMin    = 8'h81;
  localparam logic [7:0] LeadMax    = 8'hFE;
  localparam logic [7:0] TrailMin   = 8'h40;
  localparam logic [7:0] TrailMax   = 8'hFE;
  // Tab, LF, VT, FF and CR form one contiguous run
  localparam logic [7:0] SpaceCtlLo = 8'h09;
  localparam logic [7:0] SpaceCtlHi = 8'h0D;

  // Control character policy
  typedef enum logic [1:0] {
    POL_IGNORE = 2'd0,
    POL_REJECT = 2'd1,
    POL_FLAG   = 2'd2,
    POL_RSVD   = 2'd3
  } policy_e;

  localparam policy_e PolicyReset = POL_REJECT;

  // Result status codes; ST_VALID also means no error
  typedef enum logic [2:0] {
    ST_VALID    = 3'd0,
    ST_CONTROL  = 3'd1,
    ST_NO_TRAIL = 3'd2,
    ST_BAD_PAIR = 3'd3,
    ST_REJECTED = 3'd4
  } status_e;

  typedef struct packed {
    status_e               status;
    logic [TotalWidth-1:0] char_total;
    logic [TotalWidth-1:0] byte_total;
  } result_t;

endpackage

>>> rtl/gsv_in_if.sv
interface gsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

>>> rtl/gsv_out_if.sv
interface gsv_out_if import gsv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [2:0]            status;
  logic [TotalWidth-1:0] char_total;
  logic [TotalWidth-1:0] byte_total;

  modport source (output valid, output status, output char_total, output byte_total,
                  input ready);
  modport sink   (input valid, input status, input char_total, input byte_total,
                  output ready);
endinterface

>>> rtl/gsv_cfg_if.sv
interface gsv_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] control_policy;

  modport source (output valid, output control_policy, input ready);
  modport sink   (input valid, input control_policy, output ready);
endinterface

>>> rtl/gsv_scan.sv
module gsv_scan import gsv_pkg::*; #(
  parameter int unsigned CountWidth = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  policy_e    policy_i,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output result_t    result_o
);

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  logic                  awaiting_q, awaiting_d;
  logic                  lead_bad_q, lead_bad_d;
  logic                  ended_q, ended_d;
  status_e               err_q, err_d;
  logic                  saw_ctl_q, saw_ctl_d;
  logic [CountWidth-1:0] char_cnt_q, char_cnt_d;
  logic [CountWidth-1:0] byte_cnt_q, byte_cnt_d;

  logic                  is_ctl;
  logic                  reject_ctl;
  logic [CountWidth:0]   char_inc;
  logic [CountWidth:0]   byte_inc1;
  logic [CountWidth:0]   byte_inc2;
  logic [CountWidth-1:0] char_sat;
  logic [CountWidth-1:0] byte_sat1;
  logic [CountWidth-1:0] byte_sat2;
  status_e               status;
  logic [CountWidth+TotalWidth-1:0] char_ext;
  logic [CountWidth+TotalWidth-1:0] byte_ext;

  // Classify the byte
  assign is_ctl     = (byte_i < CtrlLimit) && !(byte_i inside {[SpaceCtlLo:SpaceCtlHi]});
  assign reject_ctl = (policy_i == POL_REJECT) || (policy_i == POL_RSVD);

  // Saturating count increments
  assign char_inc  = {1'b0, char_cnt_q} + {{CountWidth{1'b0}}, 1'b1};
  assign byte_inc1 = {1'b0, byte_cnt_q} + {{CountWidth{1'b0}}, 1'b1};
  assign byte_inc2 = {1'b0, byte_cnt_q} + {{(CountWidth-1){1'b0}}, 2'd2};
  assign char_sat  = char_inc[CountWidth]  ? CountMax : char_inc[CountWidth-1:0];
  assign byte_sat1 = byte_inc1[CountWidth] ? CountMax : byte_inc1[CountWidth-1:0];
  assign byte_sat2 = byte_inc2[CountWidth] ? CountMax : byte_inc2[CountWidth-1:0];

  // Advance the per-string state by one byte
  always_comb begin
    awaiting_d = awaiting_q;
    lead_bad_d = lead_bad_q;
    ended_d    = ended_q;
    err_d      = err_q;
    saw_ctl_d  = saw_ctl_q;
    char_cnt_d = char_cnt_q;
    byte_cnt_d = byte_cnt_q;

    if (!ended_q && (err_q == ST_VALID)) begin
      if (byte_i == 8'h00) begin
        ended_d = 1'b1;
        if (awaiting_q) begin
          err_d = ST_NO_TRAIL;
        end
      end else if (awaiting_q) begin
        awaiting_d = 1'b0;
        if (lead_bad_q || !(byte_i inside {[TrailMin:TrailMax]})) begin
          err_d = ST_BAD_PAIR;
        end else begin
          char_cnt_d = char_sat;
          byte_cnt_d = byte_sat2;
        end
      end else if (byte_i <= AsciiMax) begin
        if (is_ctl && reject_ctl) begin
          err_d = ST_REJECTED;
        end else begin
          if (is_ctl && (policy_i == POL_FLAG)) begin
            saw_ctl_d = 1'b1;
          end
          char_cnt_d = char_sat;
          byte_cnt_d = byte_sat1;
        end
      end else begin
        awaiting_d = 1'b1;
        lead_bad_d = !(byte_i inside {[LeadMin:LeadMax]});
      end
    end

    if (err_d != ST_VALID) begin
      status = err_d;
    end else if (awaiting_d) begin
      status = ST_NO_TRAIL;
    end else if (saw_ctl_d) begin
      status = ST_CONTROL;
    end else begin
      status = ST_VALID;
    end
  end

  // Present the closing result, counts cut or padded to the field width
  assign char_ext            = {{TotalWidth{1'b0}}, char_cnt_d};
  assign byte_ext            = {{TotalWidth{1'b0}}, byte_cnt_d};
  assign result_o.status     = status;
  assign result_o.char_total = char_ext[TotalWidth-1:0];
  assign result_o.byte_total = byte_ext[TotalWidth-1:0];

  // Update on each byte, clear after the closing byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      lead_bad_q <= 1'b0;
      ended_q    <= 1'b0;
      err_q      <= ST_VALID;
      saw_ctl_q  <= 1'b0;
      char_cnt_q <= '0;
      byte_cnt_q <= '0;
    end else if (step_i) begin
      if (last_i) begin
        awaiting_q <= 1'b0;
        lead_bad_q <= 1'b0;
        ended_q    <= 1'b0;
        err_q      <= ST_VALID;
        saw_ctl_q  <= 1'b0;
        char_cnt_q <= '0;
        byte_cnt_q <= '0;
      end else begin
        awaiting_q <= awaiting_d;
        lead_bad_q <= lead_bad_d;
        ended_q    <= ended_d;
        err_q      <= err_d;
        saw_ctl_q  <= saw_ctl_d;
        char_cnt_q <= char_cnt_d;
        byte_cnt_q <= byte_cnt_d;
      end
    end
  end

  // A closing byte leaves a clean string state
  a_clear_after_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && last_i) |=> (err_q == ST_VALID) && (char_cnt_q == '0) && (byte_cnt_q == '0))
    else $error("string state not cleared after closing byte");

  // An error holds until the string closes
  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((err_q != ST_VALID) && !(step_i && last_i)) |=> (err_q == $past(err_q)))
    else $error("error code changed before string close");

  // Counts freeze once an error is recorded
  a_counts_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((err_q != ST_VALID) && !(step_i && last_i)) |=> ($stable(char_cnt_q) && $stable(byte_cnt_q)))
    else $error("counts moved after an error");

  // Every character takes at least one byte
  a_bytes_cover_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_cnt_q >= char_cnt_q)
    else $error("byte count below character count");

endmodule

>>> rtl/gsv_out_reg.sv
module gsv_out_reg import gsv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  result_t   result_i,
  output logic      free_o,
  gsv_out_if.source out_o
);

  logic    valid_q;
  result_t data_q;

  // Slot takes a new result when empty or being drained
  assign free_o = !valid_q || out_o.ready;

  // Hold the result until the sink takes the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      data_q <= result_i;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.status     = data_q.status;
  assign out_o.char_total = data_q.char_total;
  assign out_o.byte_total = data_q.byte_total;

endmodule

>>> rtl/gbk_string_validate_count.sv
// GBK string checker: bytes arrive one per transfer on in_i, last_byte closing the
// string, and exactly one result (status, character and byte totals) leaves on out_o
// for each closing byte. The block takes one byte per clock with no bubbles, except
// while a closing byte stalls; the closing byte is held in the input register, and
// its result is then loaded into the result register, from which it is valid on out_o.
// A byte stalls in the input register only while it closes a string and the result
// register is still held by the sink. Counters are COUNT_WIDTH bits and saturate; the
// result carries their low 16 bits. Write control_policy on cfg_i only while no string
// is in progress.
module gbk_string_validate_count import gsv_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gsv_cfg_if.sink   cfg_i,
  gsv_in_if.sink    in_i,
  gsv_out_if.source out_o
);

  policy_e    policy_q;
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       s1_step;
  logic       out_free;
  result_t    result;

  // Configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= PolicyReset;
    end else if (cfg_i.valid) begin
      policy_q <= policy_e'(cfg_i.control_policy);
    end
  end

  // Input register: advance unless a closing byte waits for the result slot
  assign s1_step    = s1_valid_q && (!s1_last_q || out_free);
  assign in_i.ready = !s1_valid_q || s1_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.byte_value;
      s1_last_q <= in_i.last_byte;
    end
  end

  gsv_scan #(
    .CountWidth(COUNT_WIDTH)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .policy_i(policy_q),
    .step_i  (s1_step),
    .byte_i  (s1_byte_q),
    .last_i  (s1_last_q),
    .result_o(result)
  );

  gsv_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (s1_step && s1_last_q),
    .result_i(result),
    .free_o  (out_free),
    .out_o   (out_o)
  );

endmodule
